// ===== src/spb_pkg.sv =====
`timescale 1ns / 1ps
package spb_pkg;

  // protocol bytes
  localparam logic [7:0] ACK       = 8'h06;
  localparam logic [7:0] NAK       = 8'h15;
  localparam logic [7:0] BUS_SPI   = 8'h08;
  localparam logic [7:0] SBUF_BYTE = 8'hFF;
  localparam logic [7:0] IFACE_VER = 8'h01;

  // command map header bytes
  localparam logic [7:0] MAP_B1 = 8'h3F;
  localparam logic [7:0] MAP_B3 = 8'h0D;
  localparam int         MAP_ZEROS = 29;

  // host command codes
  localparam logic [7:0] CMD_NOP    = 8'h00;
  localparam logic [7:0] CMD_IFACE  = 8'h01;
  localparam logic [7:0] CMD_MAP    = 8'h02;
  localparam logic [7:0] CMD_NAME   = 8'h03;
  localparam logic [7:0] CMD_SBUF   = 8'h04;
  localparam logic [7:0] CMD_BUST   = 8'h05;
  localparam logic [7:0] CMD_SYNC   = 8'h10;
  localparam logic [7:0] CMD_SETBUS = 8'h12;
  localparam logic [7:0] CMD_SPIOP  = 8'h13;

  // result kinds
  localparam logic [1:0] K_HOST  = 2'd0;
  localparam logic [1:0] K_XFER  = 2'd1;
  localparam logic [1:0] K_SEL   = 2'd2;
  localparam logic [1:0] K_DESEL = 2'd3;

  // response scripts: one per shape of result burst
  localparam int SC_W  = 4;
  localparam int IDX_W = 6;
  localparam logic [SC_W-1:0] SC_NONE          = 4'd0;
  localparam logic [SC_W-1:0] SC_ONE           = 4'd1;
  localparam logic [SC_W-1:0] SC_IFACE         = 4'd2;
  localparam logic [SC_W-1:0] SC_CMDMAP        = 4'd3;
  localparam logic [SC_W-1:0] SC_NAME          = 4'd4;
  localparam logic [SC_W-1:0] SC_SBUF          = 4'd5;
  localparam logic [SC_W-1:0] SC_BUST          = 4'd6;
  localparam logic [SC_W-1:0] SC_SYNC          = 4'd7;
  localparam logic [SC_W-1:0] SC_REQ           = 4'd8;
  localparam logic [SC_W-1:0] SC_SEL           = 4'd9;
  localparam logic [SC_W-1:0] SC_SEL_ACK_REQ   = 4'd10;
  localparam logic [SC_W-1:0] SC_SEL_ACK_DESEL = 4'd11;
  localparam logic [SC_W-1:0] SC_ACK_REQ       = 4'd12;
  localparam logic [SC_W-1:0] SC_ACK_DESEL     = 4'd13;
  localparam logic [SC_W-1:0] SC_HOST_REQ      = 4'd14;
  localparam logic [SC_W-1:0] SC_HOST_DESEL    = 4'd15;

  localparam logic [7:0] NAME_TABLE [32] = '{
    8'h53, 8'h50, 8'h49, 8'h2D, 8'h62, 8'h72, 8'h69, 8'h64,
    8'h67, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } res_t;

  typedef struct packed {
    logic [SC_W-1:0] script;
    logic [7:0]      data;
  } desc_t;

  function automatic logic [IDX_W-1:0] script_len(input logic [SC_W-1:0] sc,
                                                  input logic [IDX_W-1:0] name_len);
    logic [IDX_W-1:0] n;
    unique case (sc)
      SC_NONE:          n = IDX_W'(0);
      SC_ONE:           n = IDX_W'(1);
      SC_IFACE:         n = IDX_W'(3);
      SC_CMDMAP:        n = IDX_W'(4 + MAP_ZEROS);
      SC_NAME:          n = name_len;
      SC_SBUF:          n = IDX_W'(3);
      SC_BUST:          n = IDX_W'(2);
      SC_SYNC:          n = IDX_W'(2);
      SC_REQ:           n = IDX_W'(1);
      SC_SEL:           n = IDX_W'(1);
      SC_SEL_ACK_REQ:   n = IDX_W'(3);
      SC_SEL_ACK_DESEL: n = IDX_W'(3);
      SC_ACK_REQ:       n = IDX_W'(2);
      SC_ACK_DESEL:     n = IDX_W'(2);
      SC_HOST_REQ:      n = IDX_W'(2);
      SC_HOST_DESEL:    n = IDX_W'(2);
    endcase
    return n;
  endfunction

  function automatic res_t script_item(input logic [SC_W-1:0]  sc,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [7:0]       data);
    res_t r;
    r.kind  = K_HOST;
    r.value = 8'h00;
    unique case (sc)
      SC_NONE, SC_ONE: r.value = data;
      SC_IFACE: begin
        if (idx == IDX_W'(0))      r.value = ACK;
        else if (idx == IDX_W'(1)) r.value = IFACE_VER;
      end
      SC_CMDMAP: begin
        if (idx == IDX_W'(0))      r.value = ACK;
        else if (idx == IDX_W'(1)) r.value = MAP_B1;
        else if (idx == IDX_W'(3)) r.value = MAP_B3;
      end
      SC_NAME: begin
        if (idx == IDX_W'(0)) r.value = ACK;
        else                  r.value = NAME_TABLE[5'(idx - IDX_W'(1))];
      end
      SC_SBUF: r.value = (idx == IDX_W'(0)) ? ACK : SBUF_BYTE;
      SC_BUST: r.value = (idx == IDX_W'(0)) ? ACK : BUS_SPI;
      SC_SYNC: r.value = (idx == IDX_W'(0)) ? NAK : ACK;
      SC_REQ: begin
        r.kind  = K_XFER;
        r.value = data;
      end
      SC_SEL: r.kind = K_SEL;
      SC_SEL_ACK_REQ, SC_SEL_ACK_DESEL: begin
        if (idx == IDX_W'(0)) begin
          r.kind = K_SEL;
        end else if (idx == IDX_W'(1)) begin
          r.value = ACK;
        end else begin
          r.kind = (sc == SC_SEL_ACK_REQ) ? K_XFER : K_DESEL;
        end
      end
      SC_ACK_REQ, SC_ACK_DESEL: begin
        if (idx == IDX_W'(0)) r.value = ACK;
        else                  r.kind  = (sc == SC_ACK_REQ) ? K_XFER : K_DESEL;
      end
      SC_HOST_REQ, SC_HOST_DESEL: begin
        if (idx == IDX_W'(0)) r.value = data;
        else                  r.kind  = (sc == SC_HOST_REQ) ? K_XFER : K_DESEL;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/spb_if.sv =====
`timescale 1ns / 1ps
interface spb_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface spb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== src/spb_decode.sv =====
`timescale 1ns / 1ps
module spb_decode import spb_pkg::*; #(
  parameter int LENGTH_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  spb_in_if.sink     in_chan,
  input  logic       em_ready,
  output logic       desc_valid,
  output desc_t      desc
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_BUSWAIT    = 3'd1;
  localparam logic [2:0] PH_LENGTHS    = 3'd2;
  localparam logic [2:0] PH_WRITE      = 3'd3;
  localparam logic [2:0] PH_WRITE_WAIT = 3'd4;
  localparam logic [2:0] PH_READ       = 3'd5;

  localparam logic [2:0] LEN_HALF  = 3'd3;
  localparam logic [2:0] LEN_BYTES = 3'd6;

  // input register
  logic       in_v_r, in_v_nxt;
  logic       in_act_r;
  logic [7:0] in_byte_r;

  logic [2:0]              phase_r, phase_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic [LENGTH_WIDTH-1:0] wr_r, wr_nxt;
  logic [LENGTH_WIDTH-1:0] rd_r, rd_nxt;

  logic                    consume;
  logic [2:0]              cnt_inc;
  logic [1:0]              sh_sel;
  logic [31:0]             shifted;
  logic [LENGTH_WIDTH-1:0] g_wr, g_rd, wr_dec, rd_dec;
  logic [SC_W-1:0]         script;
  logic [7:0]              data;

  assign cnt_inc = cnt_r + 3'd1;
  assign sh_sel  = (cnt_r < LEN_HALF) ? cnt_r[1:0] : 2'(cnt_r - LEN_HALF);
  assign shifted = 32'(in_byte_r) << {sh_sel, 3'b000};
  assign g_wr    = (cnt_r < LEN_HALF) ? (wr_r | shifted[LENGTH_WIDTH-1:0]) : wr_r;
  assign g_rd    = (cnt_r >= LEN_HALF && cnt_r < LEN_BYTES) ?
                   (rd_r | shifted[LENGTH_WIDTH-1:0]) : rd_r;
  assign wr_dec  = wr_r - LENGTH_WIDTH'(1);
  assign rd_dec  = rd_r - LENGTH_WIDTH'(1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    script    = SC_NONE;
    data      = 8'h00;
    unique case (phase_r)
      PH_IDLE: begin
        if (!in_act_r) begin
          unique case (in_byte_r)
            CMD_NOP: begin
              script = SC_ONE;
              data   = ACK;
            end
            CMD_IFACE:  script = SC_IFACE;
            CMD_MAP:    script = SC_CMDMAP;
            CMD_NAME:   script = SC_NAME;
            CMD_SBUF:   script = SC_SBUF;
            CMD_BUST:   script = SC_BUST;
            CMD_SYNC:   script = SC_SYNC;
            CMD_SETBUS: phase_nxt = PH_BUSWAIT;
            CMD_SPIOP: begin
              phase_nxt = PH_LENGTHS;
              cnt_nxt   = 3'd0;
              wr_nxt    = '0;
              rd_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      PH_BUSWAIT: begin
        if (!in_act_r) begin
          script    = SC_ONE;
          data      = (in_byte_r == BUS_SPI) ? ACK : NAK;
          phase_nxt = PH_IDLE;
        end
      end
      PH_LENGTHS: begin
        if (!in_act_r) begin
          wr_nxt = g_wr;
          rd_nxt = g_rd;
          if (cnt_inc >= LEN_BYTES) begin
            cnt_nxt = 3'd0;
            if (g_wr != '0) begin
              script    = SC_SEL;
              phase_nxt = PH_WRITE;
            end else if (g_rd != '0) begin
              script    = SC_SEL_ACK_REQ;
              phase_nxt = PH_READ;
            end else begin
              script    = SC_SEL_ACK_DESEL;
              phase_nxt = PH_IDLE;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      PH_WRITE: begin
        if (!in_act_r) begin
          script    = SC_REQ;
          data      = in_byte_r;
          wr_nxt    = wr_dec;
          phase_nxt = PH_WRITE_WAIT;
        end
      end
      PH_WRITE_WAIT: begin
        if (in_act_r) begin
          if (wr_r != '0) begin
            phase_nxt = PH_WRITE;
          end else if (rd_r != '0) begin
            script    = SC_ACK_REQ;
            phase_nxt = PH_READ;
          end else begin
            script    = SC_ACK_DESEL;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_READ: begin
        if (in_act_r) begin
          data   = in_byte_r;
          rd_nxt = rd_dec;
          if (rd_dec != '0) begin
            script = SC_HOST_REQ;
          end else begin
            script    = SC_HOST_DESEL;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // a request with no results retires without waiting on the emitter
  assign consume     = in_v_r && (script == SC_NONE || em_ready);
  assign in_chan.ready = !in_v_r || consume;
  assign desc_valid  = in_v_r && script != SC_NONE;
  assign desc.script = script;
  assign desc.data   = data;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_chan.valid && in_chan.ready) in_v_nxt = 1'b1;
    else if (consume)                   in_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      phase_r <= PH_IDLE;
      cnt_r   <= 3'd0;
      wr_r    <= '0;
      rd_r    <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (consume) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        wr_r    <= wr_nxt;
        rd_r    <= rd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_act_r  <= in_chan.action;
      in_byte_r <= in_chan.data_byte;
    end
  end

endmodule

// ===== src/spb_emit.sv =====
`timescale 1ns / 1ps
module spb_emit import spb_pkg::*; #(
  parameter int NAME_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       desc_valid,
  input  desc_t      desc,
  output logic       em_ready,
  spb_out_if.source  out_chan
);

  localparam logic [IDX_W-1:0] NAME_LEN = IDX_W'(NAME_BYTES + 1);

  logic             cur_v_r, cur_v_nxt;
  desc_t            cur_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_v_r, out_v_nxt;
  res_t             out_res_r;
  logic             out_last_r;

  logic [IDX_W-1:0] len;
  logic             is_last, out_load, load;
  res_t             item;

  assign len      = script_len(cur_r.script, NAME_LEN);
  assign is_last  = idx_r == len - IDX_W'(1);
  assign item     = script_item(cur_r.script, idx_r, cur_r.data);
  assign out_load = cur_v_r && (!out_v_r || out_chan.ready);
  assign em_ready = !cur_v_r || (out_load && is_last);
  assign load     = desc_valid && em_ready;

  always_comb begin
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (load) begin
      cur_v_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (out_load) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (is_last) cur_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_load)            out_v_nxt = 1'b1;
    else if (out_chan.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= desc;
    if (out_load) begin
      out_res_r  <= item;
      out_last_r <= is_last;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.kind  = out_res_r.kind;
  assign out_chan.value = out_res_r.value;
  assign out_chan.last  = out_last_r;

endmodule

// ===== src/serial_flash_programmer_bridge.sv =====
`timescale 1ns / 1ps
// Path: a request is taken into the input register and decoded there combinationally into a
// response script, which the emitter's script register walks into the output register.
// Throughput: one request a cycle while each yields at most one result and the output is not
// stalled; a burst holds the emitter until its last result leaves, the single output register sets this pace.
// Reset: synchronous, active low; returns to idle awaiting a command byte, lengths cleared.
module serial_flash_programmer_bridge import spb_pkg::*; #(
  parameter int LENGTH_WIDTH = 24,
  parameter int NAME_BYTES   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spb_in_if.sink    in_chan,
  spb_out_if.source out_chan
);

  // decode -> emitter hand-off: one response script plus its data byte
  logic  desc_valid;
  logic  em_ready;
  desc_t desc;

  // Decoder: input register, phase/length state and command decode.
  // State advances only when the request retires into the emitter,
  // or at once for requests that produce nothing (dropped inputs,
  // unknown codes, length bytes before the sixth).
  spb_decode #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .em_ready   (em_ready),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  // Emitter: walks the script into the output register one result a cycle
  // while the output is not stalled; takes the next script on the cycle its last result leaves,
  // so bursts from back-to-back requests run without a gap.
  spb_emit #(
    .NAME_BYTES(NAME_BYTES)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc       (desc),
    .em_ready   (em_ready),
    .out_chan   (out_chan)
  );

endmodule

// ===== src/spb_checker.sv =====
`timescale 1ns / 1ps
module spb_checker import spb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_value,
  input logic       out_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_desel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_DESEL |-> out_last)
    else $error("select deassert not final result");

  a_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_SEL || out_kind == K_DESEL) |-> out_value == 8'h00)
    else $error("select event carries data");

endmodule

bind serial_flash_programmer_bridge spb_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.kind),
  .out_value (out_chan.value),
  .out_last  (out_chan.last)
);

// ===== test/serial_flash_programmer_bridge_tb.sv =====
`timescale 1ns / 1ps
module serial_flash_programmer_bridge_tb import spb_pkg::*;;

  localparam int LEN_BITS = 24;
  localparam int NAME_LEN = 16;

  // request source: host stream or byte handed back by the SPI shifter
  localparam logic SRC_HOST = 1'b0;
  localparam logic SRC_SPI  = 1'b1;

  // requests per random phase, and the receiver's long hold-off in cycles
  localparam int PHASE_ITEMS = 40;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    AWAIT_CMD,
    AWAIT_BUS,
    GATHER_LEN,
    SEND_WRITE,
    WAIT_WRITE,
    RELAY_READ
  } op_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } answer_t;

  // Tracks the bridge's protocol state and holds the answers still owed.
  class bridge_scoreboard;
    op_state_t          op_state;
    logic [2:0]         len_count;
    logic [LEN_BITS-1:0] write_left;
    logic [LEN_BITS-1:0] read_left;
    answer_t            expected_answers[$];
    answer_t            burst[$];
    int                 mismatch_count;

    function new();
      op_state       = AWAIT_CMD;
      len_count      = '0;
      write_left     = '0;
      read_left      = '0;
      mismatch_count = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    function void emit(input logic [1:0] k, input logic [7:0] v);
      answer_t r;
      r.kind  = k;
      r.value = v;
      r.last  = 1'b0;
      burst.push_back(r);
    endfunction

    // write phase over: ACK, then first read or deselect
    function void close_writes();
      emit(K_HOST, ACK);
      if (read_left != '0) begin
        emit(K_XFER, 8'h00);
        op_state = RELAY_READ;
      end else begin
        emit(K_DESEL, 8'h00);
        op_state = AWAIT_CMD;
      end
    endfunction

    function void decode_command(input logic [7:0] cmd);
      int i;
      case (cmd)
        CMD_NOP: emit(K_HOST, ACK);
        CMD_IFACE: begin
          emit(K_HOST, ACK);
          emit(K_HOST, IFACE_VER);
          emit(K_HOST, 8'h00);
        end
        CMD_MAP: begin
          emit(K_HOST, ACK);
          emit(K_HOST, MAP_B1);
          emit(K_HOST, 8'h00);
          emit(K_HOST, MAP_B3);
          for (i = 0; i < MAP_ZEROS; i++) emit(K_HOST, 8'h00);
        end
        CMD_NAME: begin
          emit(K_HOST, ACK);
          for (i = 0; i < NAME_LEN; i++) emit(K_HOST, NAME_TABLE[i]);
        end
        CMD_SBUF: begin
          emit(K_HOST, ACK);
          emit(K_HOST, SBUF_BYTE);
          emit(K_HOST, SBUF_BYTE);
        end
        CMD_BUST: begin
          emit(K_HOST, ACK);
          emit(K_HOST, BUS_SPI);
        end
        CMD_SYNC: begin
          emit(K_HOST, NAK);
          emit(K_HOST, ACK);
        end
        CMD_SETBUS: op_state = AWAIT_BUS;
        CMD_SPIOP: begin
          op_state   = GATHER_LEN;
          len_count  = '0;
          write_left = '0;
          read_left  = '0;
        end
        default: ;
      endcase
    endfunction

    // works out every answer one accepted request owes
    function void note_request(input logic src, input logic [7:0] b);
      int i;
      answer_t r;
      burst.delete();
      case (op_state)
        AWAIT_CMD: if (src == SRC_HOST) decode_command(b);
        AWAIT_BUS: if (src == SRC_HOST) begin
          emit(K_HOST, (b == BUS_SPI) ? ACK : NAK);
          op_state = AWAIT_CMD;
        end
        GATHER_LEN: if (src == SRC_HOST) begin
          // two little-endian lengths, write first
          if (len_count < 3)
            write_left |= LEN_BITS'(b) << (8 * int'(len_count));
          else
            read_left |= LEN_BITS'(b) << (8 * (int'(len_count) - 3));
          len_count++;
          if (len_count == 3'd6) begin
            len_count = '0;
            emit(K_SEL, 8'h00);
            if (write_left != '0) op_state = SEND_WRITE;
            else close_writes();
          end
        end
        SEND_WRITE: if (src == SRC_HOST) begin
          emit(K_XFER, b);
          write_left--;
          op_state = WAIT_WRITE;
        end
        WAIT_WRITE: if (src == SRC_SPI) begin
          // returned byte of a write is thrown away
          if (write_left != '0) op_state = SEND_WRITE;
          else close_writes();
        end
        RELAY_READ: if (src == SRC_SPI) begin
          emit(K_HOST, b);
          read_left--;
          if (read_left != '0) begin
            emit(K_XFER, 8'h00);
          end else begin
            emit(K_DESEL, 8'h00);
            op_state = AWAIT_CMD;
          end
        end
        default: op_state = AWAIT_CMD;
      endcase
      for (i = 0; i < burst.size(); i++) begin
        r      = burst[i];
        r.last = (i == burst.size() - 1);
        expected_answers.push_back(r);
      end
    endfunction

    task check_result(input logic [1:0] k, input logic [7:0] v, input logic l);
      answer_t want;
      if (expected_answers.size() == 0) begin
        report($sformatf("result with nothing owed: kind %0d value %02h last %0d", k, v, l));
      end else begin
        want = expected_answers.pop_front();
        if (k !== want.kind)
          report($sformatf("kind %0d, want %0d", k, want.kind));
        if (v !== want.value)
          report($sformatf("value %02h, want %02h (kind %0d)", v, want.value, want.kind));
        if (l !== want.last)
          report($sformatf("last %0d, want %0d (kind %0d value %02h)", l, want.last,
                           want.kind, want.value));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  spb_in_if  in_chan ();
  spb_out_if out_chan ();

  serial_flash_programmer_bridge #(
    .LENGTH_WIDTH(LEN_BITS),
    .NAME_BYTES  (NAME_LEN)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  bridge_scoreboard sb = new();

  // idling knobs, changed per phase by the main sequence
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_order = 0;
  int hold_left  = 0;
  int items_done = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Both handshakes are sampled at the edge, before any flop updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_request(in_chan.action, in_chan.data_byte);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.kind, out_chan.value, out_chan.last);
    end
  end

  // Result receiver. A long hold-off is counted here, in cycles, so the
  // sender keeps pushing and the bridge backs up into its input.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_order > 0) begin
        hold_left  = hold_order;
        hold_order = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request and wait for it to be taken. Called just after an edge.
  task automatic send_request(input logic src, input logic [7:0] b, input bit dropped);
    while ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.action    <= src;
    in_chan.data_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    if (!dropped) items_done++;
  endtask

  // Full SPI operation; stops after write_cap writes if the write length
  // is larger. noise_pct sprinkles requests of the wrong kind, all dropped.
  task automatic run_spi_op(input logic [LEN_BITS-1:0] wlen, input logic [LEN_BITS-1:0] rlen,
                            input int unsigned write_cap, input int noise_pct);
    int unsigned writes;
    int unsigned i;
    writes = (wlen > write_cap) ? write_cap : int'(wlen);
    send_request(SRC_HOST, CMD_SPIOP, 1'b0);
    if ($urandom_range(99) < noise_pct) send_request(SRC_SPI, 8'($urandom), 1'b1);
    for (i = 0; i < 3; i++) send_request(SRC_HOST, wlen[i*8 +: 8], 1'b0);
    for (i = 0; i < 3; i++) send_request(SRC_HOST, rlen[i*8 +: 8], 1'b0);
    for (i = 0; i < writes; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(SRC_SPI, 8'($urandom), 1'b1);
      send_request(SRC_HOST, 8'($urandom), 1'b0);
      if ($urandom_range(99) < noise_pct) send_request(SRC_HOST, 8'($urandom), 1'b1);
      send_request(SRC_SPI, 8'($urandom), 1'b0);
    end
    if (writes == wlen) begin
      for (i = 0; i < rlen; i++) begin
        if ($urandom_range(99) < noise_pct) send_request(SRC_HOST, 8'($urandom), 1'b1);
        send_request(SRC_SPI, 8'($urandom), 1'b0);
      end
    end
  endtask

  function automatic logic [LEN_BITS-1:0] pick_length();
    if ($urandom_range(11) == 0) return LEN_BITS'($urandom_range(5, 40));
    return LEN_BITS'($urandom_range(0, 4));
  endfunction

  // One random sequence: mostly well-formed, some noise.
  task automatic random_sequence();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 55) begin
      run_spi_op(pick_length(), pick_length(), 32'hFFFF_FFFF, 10);
    end else if (pick < 85) begin
      case ($urandom_range(7))
        0: send_request(SRC_HOST, CMD_NOP, 1'b0);
        1: send_request(SRC_HOST, CMD_IFACE, 1'b0);
        2: send_request(SRC_HOST, CMD_MAP, 1'b0);
        3: send_request(SRC_HOST, CMD_NAME, 1'b0);
        4: send_request(SRC_HOST, CMD_SBUF, 1'b0);
        5: send_request(SRC_HOST, CMD_BUST, 1'b0);
        6: send_request(SRC_HOST, CMD_SYNC, 1'b0);
        default: begin
          send_request(SRC_HOST, CMD_SETBUS, 1'b0);
          if ($urandom_range(3) == 0) send_request(SRC_SPI, 8'($urandom), 1'b1);
          b = $urandom_range(1) ? BUS_SPI : 8'($urandom);
          send_request(SRC_HOST, b, 1'b0);
        end
      endcase
    end else if (pick < 93) begin
      // random opcode, possibly a known one; keep clear of the two that open a multi-byte command
      b = 8'($urandom);
      if (b == CMD_SETBUS || b == CMD_SPIOP) b = 8'hFF;
      send_request(SRC_HOST, b, 1'b0);
    end else begin
      // stray SPI byte while idle
      send_request(SRC_SPI, 8'($urandom), 1'b1);
    end
  endtask

  int gap_by_phase[5]   = '{0, 68, 0, 35, 0};
  int stall_by_phase[5] = '{0, 0, 68, 35, 0};

  initial begin
    int p;
    int start;
    int drain;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.action    <= SRC_HOST;
    in_chan.data_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every query, bus select both ways, unknown opcode,
    // stray SPI byte, and SPI ops with and without a data phase
    send_request(SRC_HOST, CMD_NOP, 1'b0);
    send_request(SRC_HOST, CMD_IFACE, 1'b0);
    send_request(SRC_HOST, CMD_MAP, 1'b0);
    send_request(SRC_HOST, CMD_NAME, 1'b0);
    send_request(SRC_HOST, CMD_SBUF, 1'b0);
    send_request(SRC_HOST, CMD_BUST, 1'b0);
    send_request(SRC_HOST, CMD_SYNC, 1'b0);
    send_request(SRC_HOST, CMD_SETBUS, 1'b0);
    send_request(SRC_HOST, BUS_SPI, 1'b0);
    send_request(SRC_HOST, CMD_SETBUS, 1'b0);
    send_request(SRC_HOST, 8'hF7, 1'b0);
    send_request(SRC_HOST, 8'hFF, 1'b0);
    send_request(SRC_SPI, 8'h5A, 1'b1);
    // zero lengths: select, ACK and deselect at once
    run_spi_op('0, '0, 32'hFFFF_FFFF, 0);
    // one write, one read, with wrong-kind bytes in every wait
    run_spi_op(LEN_BITS'(1), LEN_BITS'(1), 32'hFFFF_FFFF, 100);

    for (p = 0; p < 5; p++) begin
      gap_pct   = gap_by_phase[p];
      stall_pct = stall_by_phase[p];
      if (p == 4) hold_order = HOLD_CYCLES;
      start = items_done;
      while (items_done - start < PHASE_ITEMS) random_sequence();
    end

    // Top length bytes at their maximum: the op can never finish, so it
    // goes last and only its first few writes are run.
    gap_pct   = 0;
    stall_pct = 0;
    run_spi_op({LEN_BITS{1'b1}}, {LEN_BITS{1'b1}}, 3, 0);
    in_chan.valid <= 1'b0;

    while (sb.expected_answers.size() != 0) @(posedge clk);
    // let any stray result surface
    for (drain = 0; drain < 16; drain++) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
